>>> design/note_voice_track_allocator_macros.svh
// ----------------------------------------------------------------------------
// Note voice track allocator assertion macros
// Shared property templates, clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NOTE_VOICE_TRACK_ALLOCATOR_MACROS_SVH
`define NOTE_VOICE_TRACK_ALLOCATOR_MACROS_SVH

// Same-cycle implication
`define NVTA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nvta: same-cycle check failed");

// Next-cycle implication
`define NVTA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nvta: next-cycle check failed");

`endif

>>> design/nvta_pkg.sv
// ----------------------------------------------------------------------------
// Note voice track allocator package
// Shared constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package nvta_pkg;

  localparam int TRACK_SLOTS_DEF = 32;

  localparam int NOTE_W  = 7;
  localparam int MACH_W  = 8;
  localparam int INSTR_W = 8;
  localparam int TRK_W   = 5;
  localparam int TCNT_W  = 6;
  localparam int OCT_W   = 4;
  localparam int CFG_W   = 8;
  localparam int CIDX_W  = 2;

  localparam logic [NOTE_W-1:0] FREE_NOTE = 7'd120;
  localparam logic [NOTE_W-1:0] TOP_NOTE  = 7'd119;
  localparam int                SEMITONES = 12;

  localparam logic [TCNT_W-1:0] TCNT_RST  = 6'd16;
  localparam logic [OCT_W-1:0]  OCT_RST   = 4'd4;

  typedef enum logic [CIDX_W-1:0] {
    CFG_TRACK_COUNT = 2'd0,
    CFG_OCTAVE      = 2'd1,
    CFG_INSTRUMENT  = 2'd2,
    CFG_BUS_MACHINE = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REL1,
    ST_MOD,
    ST_SRCH,
    ST_REL2,
    ST_PUT,
    ST_DONE
  } nvta_state_t;

endpackage

>>> design/note_voice_track_allocator.sv
// ----------------------------------------------------------------------------
// Note voice track allocator
// Round-robin track allocation for live note-on and note-off words.
// ----------------------------------------------------------------------------
// Usage: present a word on the in_ ports with start high while busy is low.
// The block then scans its track table under a small sequencer and emits
// one event word per cycle at most on the out_ ports, each shown for one
// cycle under out_strobe; out_last marks the final word of an input.
// A note-off word scans all tracks in use once. A note-on word adds a start-index
// reduction (one subtract per cycle), a free track search and, when a track
// is stolen, a second release scan. The table sits in one RAM with one read
// and one write port; each scan visits one track per cycle. The last word
// leaves in the same cycle that the sequencer returns to idle.
// Reset restores the configuration registers to their defaults, marks every
// track free and clears the last-used track; no clearing pass is needed. The
// receiver cannot stall, so no word is ever held back by the output.
// The user must write registers through cfg_ only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "note_voice_track_allocator_macros.svh"

module note_voice_track_allocator #(
  parameter int TRACK_SLOTS = nvta_pkg::TRACK_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic [nvta_pkg::NOTE_W-1:0]  in_note,
  input  logic                         in_transpose,
  input  logic                         in_use_bus,
  input  logic [nvta_pkg::MACH_W-1:0]  in_target_machine,
  output logic                         out_strobe,
  output logic [nvta_pkg::TRK_W-1:0]   out_track,
  output logic [nvta_pkg::NOTE_W-1:0]  out_event_note,
  output logic [nvta_pkg::MACH_W-1:0]  out_machine,
  output logic [nvta_pkg::INSTR_W-1:0] out_event_instrument,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic [nvta_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [nvta_pkg::CFG_W-1:0]   cfg_wdata
);

  import nvta_pkg::*;

  localparam int IDX_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int CNT_W = $clog2(TRACK_SLOTS + 1);
  localparam int SW    = CNT_W + 1;
  localparam int SUM_W = 9;

  // configuration
  logic [TCNT_W-1:0]  trk_cnt_r;
  logic [OCT_W-1:0]   oct_r;
  logic [INSTR_W-1:0] instr_r;
  logic [MACH_W-1:0]  bus_r;

  // sequencer
  nvta_state_t state_r, state_nxt;
  logic              op_r, op_nxt;
  logic [NOTE_W-1:0] note_r, note_nxt;
  logic [NOTE_W-1:0] match_r, match_nxt;
  logic [NOTE_W-1:0] steal_r, steal_nxt;
  logic [MACH_W-1:0] mach_r, mach_nxt;
  logic [CNT_W-1:0]  tc_r, tc_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              insp_r, insp_nxt;
  logic [IDX_W-1:0]  insp_idx_r, insp_idx_nxt;
  logic [CNT_W-1:0]  mod_r, mod_nxt;
  logic [IDX_W-1:0]  t_r, t_nxt;
  logic              first_r, first_nxt;
  logic [IDX_W-1:0]  last_trk_r, last_trk_nxt;

  // one-deep event hold so the final word can be flagged
  logic              ev_vld_r, ev_vld_nxt;
  logic [IDX_W-1:0]  ev_trk_r, ev_trk_nxt;
  logic [NOTE_W-1:0] ev_note_r, ev_note_nxt;

  logic               out_strobe_r, out_strobe_nxt;
  logic [TRK_W-1:0]   out_track_r, out_track_nxt;
  logic [NOTE_W-1:0]  out_note_r, out_note_nxt;
  logic [MACH_W-1:0]  out_mach_r, out_mach_nxt;
  logic [INSTR_W-1:0] out_instr_r, out_instr_nxt;
  logic               out_last_r, out_last_nxt;

  // track table
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [NOTE_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [NOTE_W-1:0] ram_rdata;
  logic              valid_r [TRACK_SLOTS];
  logic              rvld_r;
  logic [NOTE_W-1:0] rd_note;

  logic              emit;
  logic [IDX_W-1:0]  emit_trk;
  logic [NOTE_W-1:0] emit_note;
  logic              flush;

  logic [SUM_W-1:0]  sum;
  logic [NOTE_W-1:0] nt_eff;
  logic [CNT_W-1:0]  tc_eff;
  logic [IDX_W-1:0]  rd_idx_inc;

  nvta_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (TRACK_SLOTS),
    .AW    (IDX_W)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_note = rvld_r ? ram_rdata : FREE_NOTE;
  assign busy    = (state_r != ST_IDLE);

  // effective note and clamped track count at accept time
  always_comb begin
    sum = SUM_W'(in_note);
    if (in_transpose) begin
      sum = SUM_W'(in_note) + SUM_W'(oct_r) * SUM_W'(SEMITONES);
    end
    nt_eff = in_note;
    if (in_note < FREE_NOTE) begin
      nt_eff = (sum > SUM_W'(TOP_NOTE)) ? TOP_NOTE : NOTE_W'(sum);
    end
    if (trk_cnt_r == '0) begin
      tc_eff = CNT_W'(1);
    end else if ({1'b0, trk_cnt_r} > (TCNT_W + 1)'(TRACK_SLOTS)) begin
      tc_eff = CNT_W'(TRACK_SLOTS);
    end else begin
      tc_eff = CNT_W'(trk_cnt_r);
    end
  end

  assign rd_idx_inc = (SW'(rd_idx_r) + SW'(1) == SW'(tc_r)) ? '0 : rd_idx_r + IDX_W'(1);

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    note_nxt     = note_r;
    match_nxt    = match_r;
    steal_nxt    = steal_r;
    mach_nxt     = mach_r;
    tc_nxt       = tc_r;
    rd_idx_nxt   = rd_idx_r;
    left_nxt     = left_r;
    insp_nxt     = 1'b0;
    insp_idx_nxt = rd_idx_r;
    mod_nxt      = mod_r;
    t_nxt        = t_r;
    first_nxt    = first_r;
    last_trk_nxt = last_trk_r;
    ram_we       = 1'b0;
    ram_waddr    = insp_idx_r;
    ram_wdata    = FREE_NOTE;
    ram_raddr    = rd_idx_r;
    emit         = 1'b0;
    emit_trk     = insp_idx_r;
    emit_note    = FREE_NOTE;
    flush        = 1'b0;

    // issue one table read per cycle while scanning
    if ((state_r == ST_REL1 || state_r == ST_SRCH || state_r == ST_REL2) &&
        left_r != '0) begin
      insp_nxt   = 1'b1;
      rd_idx_nxt = rd_idx_inc;
      left_nxt   = left_r - CNT_W'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt     = in_op;
          note_nxt   = nt_eff;
          match_nxt  = nt_eff;
          mach_nxt   = in_use_bus ? bus_r : in_target_machine;
          tc_nxt     = tc_eff;
          rd_idx_nxt = '0;
          left_nxt   = tc_eff;
          state_nxt  = ST_REL1;
        end
      end
      ST_REL1, ST_REL2: begin
        if (insp_r && rd_note == match_r) begin
          ram_we = 1'b1;
          emit   = 1'b1;
        end
        if (left_r == '0 && !insp_r) begin
          if (state_r == ST_REL2) begin
            state_nxt = ST_PUT;
          end else if (op_r) begin
            state_nxt = ST_DONE;
          end else begin
            mod_nxt   = CNT_W'(last_trk_r) + CNT_W'(1);
            state_nxt = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        // reduce the start index modulo the track count
        if (mod_r >= tc_r) begin
          mod_nxt = mod_r - tc_r;
        end else begin
          t_nxt      = IDX_W'(mod_r);
          rd_idx_nxt = IDX_W'(mod_r);
          left_nxt   = tc_r;
          first_nxt  = 1'b1;
          state_nxt  = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (insp_r) begin
          first_nxt = 1'b0;
          if (first_r) begin
            steal_nxt = rd_note;
          end
          if (rd_note == FREE_NOTE) begin
            // free track found: drop the read in flight
            t_nxt     = insp_idx_r;
            insp_nxt  = 1'b0;
            state_nxt = ST_PUT;
          end
        end else if (left_r == '0) begin
          if (steal_r < FREE_NOTE) begin
            match_nxt  = steal_r;
            rd_idx_nxt = '0;
            left_nxt   = tc_r;
            state_nxt  = ST_REL2;
          end else begin
            state_nxt = ST_PUT;
          end
        end
      end
      ST_PUT: begin
        ram_we       = 1'b1;
        ram_waddr    = t_r;
        ram_wdata    = note_r;
        emit         = 1'b1;
        emit_trk     = t_r;
        emit_note    = note_r;
        last_trk_nxt = t_r;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        flush     = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // event hold and output word
  always_comb begin
    ev_vld_nxt     = ev_vld_r;
    ev_trk_nxt     = ev_trk_r;
    ev_note_nxt    = ev_note_r;
    out_strobe_nxt = 1'b0;
    out_track_nxt  = TRK_W'(ev_trk_r);
    out_note_nxt   = ev_note_r;
    out_mach_nxt   = mach_r;
    out_instr_nxt  = instr_r;
    out_last_nxt   = flush;
    if (emit) begin
      out_strobe_nxt = ev_vld_r;
      ev_vld_nxt     = 1'b1;
      ev_trk_nxt     = emit_trk;
      ev_note_nxt    = emit_note;
    end else if (flush) begin
      out_strobe_nxt = ev_vld_r;
      ev_vld_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      insp_r       <= 1'b0;
      last_trk_r   <= '0;
      ev_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      trk_cnt_r    <= TCNT_RST;
      oct_r        <= OCT_RST;
      instr_r      <= '0;
      bus_r        <= '0;
      for (int i = 0; i < TRACK_SLOTS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r      <= state_nxt;
      insp_r       <= insp_nxt;
      last_trk_r   <= last_trk_nxt;
      ev_vld_r     <= ev_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TRACK_COUNT: trk_cnt_r <= cfg_wdata[TCNT_W-1:0];
          CFG_OCTAVE:      oct_r     <= cfg_wdata[OCT_W-1:0];
          CFG_INSTRUMENT:  instr_r   <= cfg_wdata[INSTR_W-1:0];
          CFG_BUS_MACHINE: bus_r     <= cfg_wdata[MACH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    note_r      <= note_nxt;
    match_r     <= match_nxt;
    steal_r     <= steal_nxt;
    mach_r      <= mach_nxt;
    tc_r        <= tc_nxt;
    rd_idx_r    <= rd_idx_nxt;
    left_r      <= left_nxt;
    insp_idx_r  <= insp_idx_nxt;
    mod_r       <= mod_nxt;
    t_r         <= t_nxt;
    first_r     <= first_nxt;
    ev_trk_r    <= ev_trk_nxt;
    ev_note_r   <= ev_note_nxt;
    out_track_r <= out_track_nxt;
    out_note_r  <= out_note_nxt;
    out_mach_r  <= out_mach_nxt;
    out_instr_r <= out_instr_nxt;
    out_last_r  <= out_last_nxt;
    rvld_r      <= valid_r[ram_raddr];
  end

  assign out_strobe           = out_strobe_r;
  assign out_track            = out_track_r;
  assign out_event_note       = out_note_r;
  assign out_machine          = out_mach_r;
  assign out_event_instrument = out_instr_r;
  assign out_last             = out_last_r;

  `NVTA_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `NVTA_ASSERT_NXT(a_last_gap, out_strobe && out_last, !out_strobe)
  `NVTA_ASSERT_IMP(a_idle_no_insp, state_r == ST_IDLE, !insp_r)
  `NVTA_ASSERT_IMP(a_we_phase, ram_we,
                   state_r == ST_REL1 || state_r == ST_REL2 || state_r == ST_PUT)
  `NVTA_ASSERT_IMP(a_put_note_on, state_r == ST_PUT, !op_r)

endmodule

>>> design/nvta_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nvta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
